/* rtl/core/chbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash bucket table package
// Sizes, field layouts, request and status codes, and controller states shared
// by the hash table core.
// ----------------------------------------------------------------------------
package chbt_pkg;

    localparam int NUM_BUCKETS  = 11;
    localparam int BUCKET_DEPTH = 8;
    localparam int KEY_WIDTH    = 16;

    // Fixed transaction field widths.
    localparam int REQ_TYPE_W = 2;
    localparam int KEY_VAL_W  = 16;
    localparam int RBKT_W     = 4;
    localparam int RSLOT_W    = 3;
    localparam int STATUS_W   = 2;
    localparam int BIDX_W     = 4;
    localparam int ENTRY_W    = 4;
    localparam int VALUE_W    = 16;

    // Derived storage widths.
    localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

    // Key modulo the bucket count by multiplying with a rounded-up reciprocal.
    // With this shift the quotient is exact for every key of KEY_WIDTH bits.
    localparam int MOD_SHIFT = KEY_WIDTH + $clog2(NUM_BUCKETS);
    localparam int MULT_W    = KEY_WIDTH + 1;
    localparam int PROD_W    = KEY_WIDTH + MULT_W;
    localparam logic [MULT_W-1:0] MOD_MULT =
        MULT_W'(((64'd1 << MOD_SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_NONE   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [KEY_VAL_W-1:0]  key_value;
        logic [RBKT_W-1:0]     read_bucket;
        logic [RSLOT_W-1:0]    read_slot;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIDX_W-1:0]   bucket_index;
        logic [ENTRY_W-1:0]  entry_count;
        logic [VALUE_W-1:0]  read_value;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [KEY_WIDTH-1:0] wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_LOOKUP,
        ST_READ,
        ST_INSERT,
        ST_DELETE,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                    input logic [SLOT_W-1:0] slot);
        return ADDR_W'(ADDR_W'(bkt) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(slot));
    endfunction

endpackage

/* rtl/core/chained_hash_bucket_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash bucket table
// Hash table with fixed-depth buckets selected by key modulo the bucket count:
// insert at the tail, delete all matches with compaction, read by bucket/slot.
// ----------------------------------------------------------------------------
//  Channel  Ports                       Payload   Direction
//  s_       s_valid, s_ready, s_req     req_t     request in
//  m_       m_valid, m_ready, m_res     result_t  result out
//
//  One request is processed at a time; s_ready is high only while idle.
//  A read skips the RAM access when the slot is empty or out of range;
//  a delete walks the whole bucket, one read per cycle through the store
//  RAM, so its duration grows with the bucket fill.
//  The result sits in an output register, so a new request is taken while
//  the previous result waits; the request after that waits for m_ready.
//  Reset clears the fill counters at once; the store needs no clearing.
// ----------------------------------------------------------------------------
module chained_hash_bucket_table
    import chbt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  req_t    s_req,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic                 hash_start;
    logic [KEY_WIDTH-1:0] hash_key;
    logic                 hash_done;
    logic [BKT_W-1:0]     hash_bucket;
    mem_req_t             mem_req;
    logic [KEY_WIDTH-1:0] mem_rdata;
    logic                 out_free;
    logic                 res_valid;
    result_t              res;
    logic                 m_valid_reg;
    result_t              m_res_reg;

    assign out_free = !m_valid_reg || m_ready;

    chbt_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (hash_key),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    chbt_ram #(
        .DATA_W (KEY_WIDTH),
        .DEPTH  (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    chbt_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .hash_start  (hash_start),
        .hash_key    (hash_key),
        .hash_done   (hash_done),
        .hash_bucket (hash_bucket),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

/* rtl/core/chbt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chbt_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 88,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/chbt_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket hash unit
// Two-stage pipeline that computes key modulo the bucket count with a
// reciprocal multiply followed by a constant multiply and subtract.
// ----------------------------------------------------------------------------
module chbt_mod
    import chbt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [KEY_WIDTH-1:0] key,
    output logic                 done,
    output logic [BKT_W-1:0]     bucket
);

    logic                 v1_reg;
    logic                 v2_reg;
    logic [KEY_WIDTH-1:0] key1_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [BKT_W-1:0]     bucket_reg;
    logic [KEY_WIDTH-1:0] quot;
    logic [KEY_WIDTH-1:0] rem;

    always_comb begin
        quot = KEY_WIDTH'(prod_reg >> MOD_SHIFT);
        rem  = key1_reg - KEY_WIDTH'(quot * KEY_WIDTH'(NUM_BUCKETS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key1_reg   <= key;
        prod_reg   <= PROD_W'(key) * PROD_W'(MOD_MULT);
        bucket_reg <= BKT_W'(rem);
    end

    assign done   = v2_reg;
    assign bucket = bucket_reg;

`ifndef SYNTHESIS
    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (32'(bucket_reg) < NUM_BUCKETS))
        else $error("hash bucket out of range");

    a_pipe_order: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> ##1 v2_reg)
        else $error("hash result did not follow start by two cycles");
`endif

endmodule

/* rtl/core/chbt_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket table controller
// Sequences insert, delete and read transactions against the bucket store,
// keeps the per-bucket fill counters and builds the result.
// ----------------------------------------------------------------------------
module chbt_engine
    import chbt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  req_t                 s_req,
    output logic                 hash_start,
    output logic [KEY_WIDTH-1:0] hash_key,
    input  logic                 hash_done,
    input  logic [BKT_W-1:0]     hash_bucket,
    output mem_req_t             mem_req,
    input  logic [KEY_WIDTH-1:0] mem_rdata,
    input  logic                 out_free,
    output logic                 res_valid,
    output result_t              res
);

    state_t               state_reg, state_next;
    req_t                 req_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [BKT_W-1:0]     bkt_reg, bkt_next;
    logic [CNT_W-1:0]     fill_reg [NUM_BUCKETS];
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]     wr_cnt_reg, wr_cnt_next;
    logic                 rvalid_reg, rvalid_next;
    result_t              res_reg, res_next;

    logic                 s_accept;
    logic [CNT_W-1:0]     cur_fill;
    logic [CNT_W-1:0]     removed;
    logic                 rb_ok;
    logic                 rs_ok;
    logic                 del_done;
    logic                 fill_we;
    logic [CNT_W-1:0]     fill_wdata;

    assign s_ready    = aresetn && (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign hash_start = s_accept
                        && (s_req.req_type == REQ_INSERT || s_req.req_type == REQ_DELETE);
    assign hash_key   = KEY_WIDTH'(s_req.key_value);

    assign cur_fill = fill_reg[bkt_reg];
    assign removed  = cur_fill - wr_cnt_reg;
    assign rb_ok    = 32'(req_reg.read_bucket) < NUM_BUCKETS;
    assign rs_ok    = (32'(req_reg.read_slot) < BUCKET_DEPTH)
                      && (32'(req_reg.read_slot) < 32'(cur_fill));
    assign del_done = (rd_cnt_reg == cur_fill) && !rvalid_reg;
    assign res      = res_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (s_req.req_type == REQ_INSERT
                                 || s_req.req_type == REQ_DELETE) begin
                        state_next = ST_HASH;
                    end else if (s_req.req_type == REQ_READ) begin
                        state_next = ST_LOOKUP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    state_next = (req_reg.req_type == REQ_INSERT) ? ST_INSERT : ST_DELETE;
                end
            end
            ST_LOOKUP: begin
                state_next = (rb_ok && rs_ok) ? ST_READ : ST_DONE;
            end
            ST_READ:   state_next = ST_DONE;
            ST_INSERT: state_next = ST_DONE;
            ST_DELETE: begin
                if (del_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        mem_req     = '0;
        bkt_next    = bkt_reg;
        rd_cnt_next = rd_cnt_reg;
        wr_cnt_next = wr_cnt_reg;
        rvalid_next = 1'b0;
        res_next    = res_reg;
        fill_we     = 1'b0;
        fill_wdata  = cur_fill;
        res_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    bkt_next = BKT_W'(s_req.read_bucket);
                end
            end
            ST_HASH: begin
                rd_cnt_next = '0;
                wr_cnt_next = '0;
                if (hash_done) begin
                    bkt_next = hash_bucket;
                end
            end
            ST_LOOKUP: begin
                res_next.status       = STAT_EMPTY;
                res_next.bucket_index = BIDX_W'(req_reg.read_bucket);
                res_next.read_value   = '0;
                if (!rb_ok) begin
                    res_next.entry_count = '0;
                end else begin
                    res_next.entry_count = ENTRY_W'(cur_fill);
                    if (rs_ok) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = slot_addr(bkt_reg, SLOT_W'(req_reg.read_slot));
                    end
                end
            end
            ST_READ: begin
                res_next.status     = STAT_OK;
                res_next.read_value = VALUE_W'(mem_rdata);
            end
            ST_INSERT: begin
                res_next.bucket_index = BIDX_W'(bkt_reg);
                res_next.read_value   = '0;
                if (32'(cur_fill) >= BUCKET_DEPTH) begin
                    res_next.status      = STAT_FULL;
                    res_next.entry_count = ENTRY_W'(cur_fill);
                end else begin
                    mem_req.we           = 1'b1;
                    mem_req.waddr        = slot_addr(bkt_reg, cur_fill[SLOT_W-1:0]);
                    mem_req.wdata        = key_reg;
                    fill_we              = 1'b1;
                    fill_wdata           = CNT_W'(cur_fill + 1'b1);
                    res_next.status      = STAT_OK;
                    res_next.entry_count = ENTRY_W'(fill_wdata);
                end
            end
            ST_DELETE: begin
                // Reads run ahead of writes, so compaction never overwrites
                // an entry that has not been read yet.
                if (rd_cnt_reg != cur_fill) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = slot_addr(bkt_reg, rd_cnt_reg[SLOT_W-1:0]);
                    rd_cnt_next   = CNT_W'(rd_cnt_reg + 1'b1);
                    rvalid_next   = 1'b1;
                end
                if (rvalid_reg && (mem_rdata != key_reg)) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = slot_addr(bkt_reg, wr_cnt_reg[SLOT_W-1:0]);
                    mem_req.wdata = mem_rdata;
                    wr_cnt_next   = CNT_W'(wr_cnt_reg + 1'b1);
                end
                if (del_done) begin
                    fill_we               = 1'b1;
                    fill_wdata            = wr_cnt_reg;
                    res_next.bucket_index = BIDX_W'(bkt_reg);
                    res_next.read_value   = '0;
                    res_next.entry_count  = ENTRY_W'(removed);
                    res_next.status       = (removed == '0) ? STAT_NOT_FOUND : STAT_OK;
                end
            end
            ST_DONE: begin
                res_valid = out_free;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            if (fill_we) begin
                fill_reg[bkt_reg] <= fill_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_req;
            key_reg <= KEY_WIDTH'(s_req.key_value);
        end
        bkt_reg    <= bkt_next;
        rd_cnt_reg <= rd_cnt_next;
        wr_cnt_reg <= wr_cnt_next;
        res_reg    <= res_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSERT || state_reg == ST_DELETE)
        |-> (32'(cur_fill) <= BUCKET_DEPTH))
        else $error("bucket fill exceeds bucket depth");

    a_write_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DELETE && mem_req.we) |-> (wr_cnt_reg < rd_cnt_reg))
        else $error("compaction write ahead of read");

    a_drop_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_req.req_type == REQ_NONE) |=> (state_reg == ST_IDLE))
        else $error("unused request code started work");
`endif

endmodule
